### design/tcgr_pkg.sv
// Shared types, codes and constants for the text console glyph renderer.
// No dependencies; imported by tcgr_ctrl, tcgr_dp and the top unit.
`default_nettype none

package tcgr_pkg;

   // Fixed field widths
   localparam int COORD_W     = 13;
   localparam int PITCH_W     = 14;
   localparam int COLOR_W     = 32;
   localparam int ADDR_W      = 27;
   localparam int FONT_ADDR_W = 12;
   localparam int CSR_IDX_W   = 3;

   // Font store geometry defaults
   localparam int GLYPH_ROWS_DEF  = 16;
   localparam int GLYPH_COUNT_DEF = 256;

   // Character cell: every glyph or blank covers sixteen rows of eight pixels
   localparam int ROWS_PER_CELL = 16;
   localparam int ROW_CNT_W     = $clog2(ROWS_PER_CELL);

   localparam logic [COORD_W-1:0] CELL_W   = 13'd8;
   localparam logic [COORD_W-1:0] CELL_H   = 13'd16;
   localparam logic [PITCH_W-1:0] TAB_STEP = 14'd32;

   localparam logic [7:0] CODE_TAB     = 8'd9;
   localparam logic [7:0] CODE_NEWLINE = 8'd10;
   localparam logic [7:0] MASK_FULL    = 8'hFF;

   // Register reset values
   localparam logic [COORD_W-1:0] WIDTH_RST  = 13'd1024;
   localparam logic [COORD_W-1:0] HEIGHT_RST = 13'd768;
   localparam logic [PITCH_W-1:0] PITCH_RST  = 14'd1024;
   localparam logic [COLOR_W-1:0] FG_RST     = 32'hFFFF_FFFF;
   localparam logic [COLOR_W-1:0] BG_RST     = 32'h0000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCREEN_WIDTH  = 3'd0,
      CSR_SCREEN_HEIGHT = 3'd1,
      CSR_LINE_PITCH    = 3'd2,
      CSR_FG_COLOR      = 3'd3,
      CSR_BG_COLOR      = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      REQ_FONT   = 2'd0,
      REQ_CHAR   = 2'd1,
      REQ_BACK   = 2'd2,
      REQ_CURSOR = 2'd3
   } req_kind_type;

   typedef enum logic {
      KIND_ROW   = 1'b0,
      KIND_CLEAR = 1'b1
   } rsp_kind_type;

   typedef struct packed {
      logic [1:0]             req_type;
      logic [7:0]             char_code;
      logic [FONT_ADDR_W-1:0] font_address;
      logic [7:0]             font_byte;
      logic [COORD_W-1:0]     new_x;
      logic [COORD_W-1:0]     new_y;
   } tcgr_req_type;

   typedef struct packed {
      logic               kind;
      logic [ADDR_W-1:0]  row_address;
      logic [7:0]         pixel_mask;
      logic [COLOR_W-1:0] color;
      logic               last;
   } tcgr_rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic setup;
      logic emit_row;
      logic emit_clear;
   } tcgr_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_draw;
      logic req_clear;
      logic out_free;
      logic row_last;
      logic end_clear;
   } tcgr_status_type;

endpackage

`default_nettype wire

### design/tcgr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tcgr_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/tcgr_ctrl.sv
// Sequencing state machine for the glyph renderer.
// Depends on tcgr_pkg for the command and status structs.
`default_nettype none

module tcgr_ctrl
   import tcgr_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire tcgr_status_type status,
   output tcgr_cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SETUP = 4'b0010,
      ST_EMIT  = 4'b0100,
      ST_CLEAR = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) begin
               if (status.req_draw) begin
                  state_in = ST_SETUP;
               end else if (status.req_clear) begin
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit_row = status.out_free;
            if (status.out_free && status.row_last) begin
               state_in = status.end_clear ? ST_CLEAR : ST_IDLE;
            end
         end
         ST_CLEAR: begin
            cmd.emit_clear = status.out_free;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

### design/tcgr_dp.sv
// Datapath: registers, cursor arithmetic, font store and result register.
// Depends on tcgr_pkg and tcgr_ram.
`default_nettype none

module tcgr_dp
   import tcgr_pkg::*;
#(
   parameter int GLYPH_ROWS  = GLYPH_ROWS_DEF,
   parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COLOR_W-1:0]   csr_wdata,
   input  wire tcgr_req_type         req_data,
   input  wire tcgr_cmd_type         cmd,
   output tcgr_status_type           status,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output tcgr_rsp_type              rsp_data
);

   localparam int STORE_SIZE = GLYPH_ROWS * GLYPH_COUNT;
   localparam int FONT_AW    = $clog2(STORE_SIZE);
   localparam int GLYPH_IW   = $clog2(GLYPH_COUNT);
   localparam int ADDR_SPAN  = 1 << FONT_ADDR_W;
   localparam int MOD_STEPS  = (ADDR_SPAN + STORE_SIZE - 1) / STORE_SIZE;
   localparam int CODE_XW    = 10;

   // Font address folded into the store: a few compare-and-subtract steps
   function automatic logic [FONT_AW-1:0] store_index(input logic [FONT_ADDR_W-1:0] a);
      int unsigned v;
      v = 32'(a);
      for (int i = 0; i < MOD_STEPS; i++) begin
         if (v >= 32'(STORE_SIZE)) begin
            v = v - 32'(STORE_SIZE);
         end
      end
      return FONT_AW'(v);
   endfunction

   // Bottom check; never fires when the height is below one cell
   function automatic logic bottom_hit(input logic [COORD_W-1:0] row,
                                       input logic [COORD_W-1:0] height);
      return (height >= CELL_H) && (({1'b0, row} + {1'b0, CELL_H}) > {1'b0, height});
   endfunction

   // Configuration registers
   logic [COORD_W-1:0] width_ff, height_ff;
   logic [PITCH_W-1:0] pitch_ff;
   logic [COLOR_W-1:0] fg_ff, bg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         pitch_ff  <= PITCH_RST;
         fg_ff     <= FG_RST;
         bg_ff     <= BG_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  width_ff  <= csr_wdata[COORD_W-1:0];
            CSR_SCREEN_HEIGHT: height_ff <= csr_wdata[COORD_W-1:0];
            CSR_LINE_PITCH:    pitch_ff  <= csr_wdata[PITCH_W-1:0];
            CSR_FG_COLOR:      fg_ff     <= csr_wdata;
            CSR_BG_COLOR:      bg_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Working registers
   logic [COORD_W-1:0]   col_ff, col_in, row_ff, row_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [FONT_AW-1:0]   fidx_ff, fidx_in;
   logic [ROW_CNT_W-1:0] rcnt_ff, rcnt_in;
   logic                 bs_ff, bs_in;

   // Request decode
   logic is_char, is_nl, is_tab, is_glyph, is_back, bs_draw;
   assign is_char  = (req_data.req_type == REQ_CHAR);
   assign is_back  = (req_data.req_type == REQ_BACK);
   assign is_nl    = is_char && (req_data.char_code == CODE_NEWLINE);
   assign is_tab   = is_char && (req_data.char_code == CODE_TAB);
   assign is_glyph = is_char && !is_nl && !is_tab;
   assign bs_draw  = is_back && (col_ff > CELL_W);

   // Line advance
   logic [COORD_W-1:0] step_row, nl_col, nl_row;
   logic               nl_hit;
   assign step_row = row_ff + CELL_H;
   assign nl_hit   = bottom_hit(step_row, height_ff);
   assign nl_col   = CELL_W;
   assign nl_row   = nl_hit ? CELL_H : step_row;

   // Tab
   logic [PITCH_W-1:0] tab_sum;
   logic               tab_wrap;
   logic [COORD_W-1:0] tab_col, tab_row;
   assign tab_sum  = {1'b0, col_ff} + TAB_STEP;
   assign tab_wrap = tab_sum > {1'b0, width_ff};
   assign tab_col  = tab_wrap ? nl_col : tab_sum[COORD_W-1:0];
   assign tab_row  = tab_wrap ? nl_row : row_ff;

   // Cursor after a glyph
   logic [PITCH_W-1:0] gl_sum;
   logic               gl_wrap, gl_clear;
   logic [COORD_W-1:0] gl_row, gl_col;
   assign gl_sum   = {1'b0, col_ff} + {1'b0, CELL_W};
   assign gl_wrap  = gl_sum > {1'b0, width_ff};
   assign gl_row   = gl_wrap ? step_row : row_ff;
   assign gl_clear = bottom_hit(gl_row, height_ff);
   assign gl_col   = gl_clear ? CELL_W : (gl_wrap ? CELL_W : gl_sum[COORD_W-1:0]);

   // Font store indexing
   logic [CODE_XW-1:0]  code_x;
   logic [GLYPH_IW-1:0] glyph_idx;
   logic [FONT_AW-1:0]  glyph_base, fidx_next, rd_addr;
   logic [7:0]          font_row;
   logic                row_last;
   assign code_x     = CODE_XW'(req_data.char_code);
   assign glyph_idx  = (code_x >= CODE_XW'(GLYPH_COUNT)) ?
                       GLYPH_IW'(code_x - CODE_XW'(GLYPH_COUNT)) : GLYPH_IW'(code_x);
   assign glyph_base = FONT_AW'(glyph_idx * GLYPH_ROWS);
   assign fidx_next  = (fidx_ff == FONT_AW'(STORE_SIZE - 1)) ? '0 : fidx_ff + 1'b1;
   assign rd_addr    = cmd.emit_row ? fidx_next : fidx_ff;
   assign row_last   = (rcnt_ff == ROW_CNT_W'(ROWS_PER_CELL - 1));

   tcgr_ram #(
      .DATA_W(8),
      .DEPTH (STORE_SIZE)
   ) u_font (
      .clock  (clock),
      .wr_en  (cmd.accept && (req_data.req_type == REQ_FONT)),
      .wr_addr(store_index(req_data.font_address)),
      .wr_data(req_data.font_byte),
      .rd_addr(rd_addr),
      .rd_data(font_row)
   );

   // Base address: one multiply, cursor column already held in addr_ff
   logic [ADDR_W-1:0] prod;
   assign prod = ADDR_W'(ADDR_W'(row_ff) * ADDR_W'(pitch_ff));

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      addr_in = addr_ff;
      fidx_in = fidx_ff;
      rcnt_in = rcnt_ff;
      bs_in   = bs_ff;
      if (cmd.accept) begin
         unique case (req_data.req_type)
            REQ_CHAR: begin
               if (is_nl) begin
                  col_in = nl_col;
                  row_in = nl_row;
               end else if (is_tab) begin
                  col_in = tab_col;
                  row_in = tab_row;
               end else begin
                  fidx_in = glyph_base;
                  rcnt_in = '0;
                  addr_in = ADDR_W'(col_ff);
                  bs_in   = 1'b0;
               end
            end
            REQ_BACK: begin
               if (bs_draw) begin
                  col_in  = col_ff - CELL_W;
                  addr_in = ADDR_W'(col_ff - CELL_W);
                  rcnt_in = '0;
                  bs_in   = 1'b1;
               end
            end
            REQ_CURSOR: begin
               col_in = req_data.new_x;
               row_in = req_data.new_y;
            end
            default: ;
         endcase
      end else if (cmd.setup) begin
         addr_in = prod + addr_ff;
      end else if (cmd.emit_row) begin
         addr_in = addr_ff + ADDR_W'(pitch_ff);
         rcnt_in = rcnt_ff + 1'b1;
         fidx_in = fidx_next;
         if (row_last && !bs_ff) begin
            col_in = gl_col;
            row_in = gl_clear ? CELL_H : gl_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= CELL_W;
         row_ff <= CELL_H;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
      addr_ff <= addr_in;
      fidx_ff <= fidx_in;
      rcnt_ff <= rcnt_in;
      bs_ff   <= bs_in;
   end

   // Result register
   logic         rsp_valid_ff;
   tcgr_rsp_type rsp_data_ff, row_word, clear_word;
   logic         end_clear;

   assign end_clear = !bs_ff && gl_clear;

   always_comb begin
      row_word.kind        = KIND_ROW;
      row_word.row_address = addr_ff;
      row_word.pixel_mask  = bs_ff ? MASK_FULL : font_row;
      row_word.color       = bs_ff ? bg_ff : fg_ff;
      row_word.last        = row_last && !end_clear;

      clear_word.kind        = KIND_CLEAR;
      clear_word.row_address = '0;
      clear_word.pixel_mask  = MASK_FULL;
      clear_word.color       = bg_ff;
      clear_word.last        = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_row || cmd.emit_clear) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit_row) begin
         rsp_data_ff <= row_word;
      end else if (cmd.emit_clear) begin
         rsp_data_ff <= clear_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.req_draw  = is_glyph || bs_draw;
   assign status.req_clear = (is_nl || (is_tab && tab_wrap)) && nl_hit;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign status.row_last  = row_last;
   assign status.end_clear = end_clear;

endmodule

`default_nettype wire

### design/text_console_glyph_renderer_unit.sv
// Text console glyph renderer: font loads, cursor moves and 8x16 glyph rows.
// A font byte load, a cursor set, and a newline or tab that needs no clear
// each complete in the idle state on acceptance. A glyph or a backspace that
// blanks a cell passes through acceptance, a setup state for the row*pitch+col
// multiply, then one row write per cycle while the output is free, each fed by
// one font RAM read. A clear-screen result at the bottom adds a clear state.
// Results leave through a register, so a stalled result holds the sequencer
// only when the next result is due. Depends on tcgr_pkg, tcgr_ctrl, tcgr_dp.
`default_nettype none

module text_console_glyph_renderer_unit
   import tcgr_pkg::*;
#(
   parameter int GLYPH_ROWS  = GLYPH_ROWS_DEF,
   parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COLOR_W-1:0]   csr_wdata,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire tcgr_req_type         req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output tcgr_rsp_type              rsp_data
);

   tcgr_cmd_type    cmd;
   tcgr_status_type status;

   tcgr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   tcgr_dp #(
      .GLYPH_ROWS (GLYPH_ROWS),
      .GLYPH_COUNT(GLYPH_COUNT)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
